>>> sv/drfd_pkg.sv
// Shared types and constants for the display reply frame decoder.
// No dependencies; imported by every module of the block.
package drfd_pkg;

   localparam int MAX_FRAME_BYTES_DEF = 32;
   localparam int COUNT_W = 6;

   localparam logic [7:0] HDR_TOUCH  = 8'h65;
   localparam logic [7:0] HDR_NUMBER = 8'h71;
   localparam logic [7:0] TERM_BYTE  = 8'hFF;

   localparam logic [1:0]         FF_RUN_END    = 2'd3;
   localparam logic [COUNT_W-1:0] TOUCH_LEN     = 6'd7;
   localparam logic [COUNT_W-1:0] NUMBER_MIN_LEN = 6'd8;

   // Reply register indexes
   localparam logic [1:0] CSR_START_PAGE     = 2'd0;
   localparam logic [1:0] CSR_START_BUTTON   = 2'd1;
   localparam logic [1:0] CSR_RESTART_PAGE   = 2'd2;
   localparam logic [1:0] CSR_RESTART_BUTTON = 2'd3;

   // Event codes
   localparam logic [1:0] EVT_START   = 2'd0;
   localparam logic [1:0] EVT_RESTART = 2'd1;
   localparam logic [1:0] EVT_NUMBER  = 2'd2;

   typedef struct packed {
      logic       hit;
      logic [1:0] kind;
   } decode_result_type;

endpackage

>>> sv/drfd_decode.sv
// Frame classifier: turns a finished frame into an event code.
// Depends on drfd_pkg.
module drfd_decode
   import drfd_pkg::*;
(
   input  logic [7:0]         header,
   input  logic [31:0]        payload,
   input  logic [COUNT_W-1:0] frame_bytes,
   input  logic [7:0]         start_page,
   input  logic [7:0]         start_button,
   input  logic [7:0]         restart_page,
   input  logic [7:0]         restart_button,
   output decode_result_type  result
);

   logic [7:0] page;
   logic [7:0] comp_id;
   logic       released;
   logic       is_touch;
   logic       is_number;
   logic       start_match;
   logic       restart_match;

   assign page     = payload[7:0];
   assign comp_id  = payload[15:8];
   assign released = (payload[23:16] == 8'h00);

   assign is_touch  = (header == HDR_TOUCH) && (frame_bytes == TOUCH_LEN);
   assign is_number = (header == HDR_NUMBER) && (frame_bytes >= NUMBER_MIN_LEN);

   assign start_match   = (page == start_page) && (comp_id == start_button);
   assign restart_match = (page == restart_page) && (comp_id == restart_button);

   always_comb begin
      result.hit  = 1'b0;
      result.kind = EVT_START;
      if (is_touch) begin
         if (released && start_match) begin
            result.hit  = 1'b1;
            result.kind = EVT_START;
         end else if (released && restart_match) begin
            result.hit  = 1'b1;
            result.kind = EVT_RESTART;
         end
      end else if (is_number) begin
         result.hit  = 1'b1;
         result.kind = EVT_NUMBER;
      end
   end

endmodule

>>> sv/display_reply_frame_decoder.sv
// Reply frame decoder, top level. Takes one received byte per cycle while
// req_ready is high; a frame ends on three 0xFF bytes in a row and may yield
// one event. A result appears on the rsp_ channel the cycle after the
// terminating byte is accepted and is held in an output register; req_ready
// drops only while that register holds a result that rsp_ready does not take.
// Depends on drfd_pkg and drfd_decode.
module display_reply_frame_decoder
   import drfd_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_event_kind,
   output logic [31:0] rsp_number_value,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   localparam logic [COUNT_W-1:0] MaxCount = COUNT_W'(MAX_FRAME_BYTES);

   logic [7:0]         start_page_ff, start_button_ff, restart_page_ff, restart_button_ff;
   logic [COUNT_W-1:0] byte_count_ff, byte_count_in;
   logic [1:0]         ff_run_ff, ff_run_in;
   logic [7:0]         header_ff, header_in;
   logic [31:0]        payload_ff, payload_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         kind_ff, kind_in;
   logic [31:0]        number_ff, number_in;

   logic               accept;
   logic               overflow;
   logic [1:0]         run_next;
   logic               frame_end;
   logic [COUNT_W-1:0] frame_bytes;
   decode_result_type  dec;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign overflow    = (byte_count_ff >= MaxCount);
   assign run_next    = (req_rx_byte == TERM_BYTE) ? ff_run_ff + 2'd1 : 2'd0;
   assign frame_end   = (run_next == FF_RUN_END);
   assign frame_bytes = byte_count_ff + COUNT_W'(1);

   // frame contents including the byte being taken now
   always_comb begin
      header_in  = (byte_count_ff == '0) ? req_rx_byte : header_ff;
      payload_in = payload_ff;
      for (int k = 0; k < 4; k++) begin
         if (byte_count_ff == COUNT_W'(k + 1))
            payload_in[8*k +: 8] = req_rx_byte;
      end
   end

   drfd_decode u_decode (
      .header         (header_in),
      .payload        (payload_in),
      .frame_bytes    (frame_bytes),
      .start_page     (start_page_ff),
      .start_button   (start_button_ff),
      .restart_page   (restart_page_ff),
      .restart_button (restart_button_ff),
      .result         (dec)
   );

   always_comb begin
      byte_count_in = byte_count_ff;
      ff_run_in     = ff_run_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      kind_in       = kind_ff;
      number_in     = number_ff;
      if (accept) begin
         if (overflow) begin
            byte_count_in = '0;
            ff_run_in     = 2'd0;
         end else if (frame_end) begin
            byte_count_in = '0;
            ff_run_in     = 2'd0;
            if (dec.hit) begin
               rsp_valid_in = 1'b1;
               kind_in      = dec.kind;
               number_in    = (dec.kind == EVT_NUMBER) ? payload_in : 32'h0;
            end
         end else begin
            byte_count_in = frame_bytes;
            ff_run_in     = run_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         ff_run_ff     <= 2'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         byte_count_ff <= byte_count_in;
         ff_run_ff     <= ff_run_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // frame storage and result payload
   always_ff @(posedge clock) begin
      if (accept && !overflow) begin
         header_ff  <= header_in;
         payload_ff <= payload_in;
      end
      kind_ff   <= kind_in;
      number_ff <= number_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_page_ff     <= 8'h00;
         start_button_ff   <= 8'h00;
         restart_page_ff   <= 8'h00;
         restart_button_ff <= 8'h00;
      end else if (csr_we) begin
         case (csr_index)
            CSR_START_PAGE:     start_page_ff     <= csr_wdata;
            CSR_START_BUTTON:   start_button_ff   <= csr_wdata;
            CSR_RESTART_PAGE:   restart_page_ff   <= csr_wdata;
            CSR_RESTART_BUTTON: restart_button_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_kind   = kind_ff;
   assign rsp_number_value = number_ff;

endmodule

>>> sv/drfd_checker.sv
// Port-level checks for display_reply_frame_decoder, with its bind.
// Depends on drfd_pkg.
module drfd_checker
   import drfd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [7:0]  req_rx_byte,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_event_kind,
   input logic [31:0] rsp_number_value
);

   // a held result must not change
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_kind)
         && $stable(rsp_number_value))
      else $error("result changed while stalled");

   // input side stalls only behind a stalled result
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without a pending result");

   // a new result always follows an accepted terminator byte
   a_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_rx_byte == TERM_BYTE))
      else $error("result without terminating byte");

   // button events carry no number, and code 3 never appears
   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_event_kind == EVT_NUMBER) ||
         ((rsp_event_kind == EVT_START || rsp_event_kind == EVT_RESTART)
          && rsp_number_value == 32'h0))
      else $error("bad result encoding");

endmodule

bind display_reply_frame_decoder drfd_checker u_drfd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_rx_byte      (req_rx_byte),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_event_kind   (rsp_event_kind),
   .rsp_number_value (rsp_number_value)
);
